/* design/qrs_pkg.sv */
// Shared constants for the quadratic root solver.
// Holds status codes, register map values and output range limits.
// No dependencies.
`default_nettype none
package qrs_pkg;

  localparam int DEF_COEF_WIDTH     = 16;
  localparam int DEF_ROOT_FRAC_BITS = 16;

  localparam int ROOT_W   = 32;
  localparam int STATUS_W = 2;
  localparam int TOL_W    = 16;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;

  localparam logic REG_TOL = 1'b0;

  localparam logic [STATUS_W-1:0] ST_NONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ONE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TWO   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_AZERO = 2'd3;

  localparam logic [ROOT_W:0] ROOT_MAX_MAG = 33'h0_7FFF_FFFF;
  localparam logic [ROOT_W:0] ROOT_MIN_MAG = 33'h0_8000_0000;

  localparam logic [ROOT_W-1:0] ROOT_MAX = 32'h7FFF_FFFF;
  localparam logic [ROOT_W-1:0] ROOT_MIN = 32'h8000_0000;

endpackage
`default_nettype wire

/* design/quadratic_root_solver.sv */
// Top level of the quadratic root solver: input, product and discriminant
// stages, the square root and divider cell chains, and the output register.
// Depends on qrs_pkg, qrs_sqrt_cell and qrs_div_cell.
//
// The solver takes one coefficient transaction every cycle while in_stall is
// low and returns one result transaction for each, in order. The pipeline is
// one register each for input, products, discriminant and numerators, one
// square root cell per root bit (COEF_WIDTH+1), one divider cell per quotient
// bit (COEF_WIDTH+2+ROOT_FRAC_BITS), and the output register. A stall on a
// valid output freezes the whole pipeline, and in_stall follows it.
`default_nettype none
module quadratic_root_solver #(
  parameter int COEF_WIDTH     = qrs_pkg::DEF_COEF_WIDTH,
  parameter int ROOT_FRAC_BITS = qrs_pkg::DEF_ROOT_FRAC_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [qrs_pkg::APB_AW-1:0]   paddr,
  input  wire logic [qrs_pkg::APB_DW-1:0]   pwdata,
  output logic [qrs_pkg::APB_DW-1:0]        prdata,
  output logic                              pready,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [COEF_WIDTH-1:0] in_coef_a,
  input  wire logic signed [COEF_WIDTH-1:0] in_coef_b,
  input  wire logic signed [COEF_WIDTH-1:0] in_coef_c,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [qrs_pkg::STATUS_W-1:0]      out_root_status,
  output logic signed [qrs_pkg::ROOT_W-1:0] out_root_plus,
  output logic signed [qrs_pkg::ROOT_W-1:0] out_root_minus,
  output logic                              out_saturated
);

  import qrs_pkg::*;

  localparam int W    = COEF_WIDTH;
  localparam int F    = ROOT_FRAC_BITS;
  localparam int DW   = 2 * W + 2;
  localparam int RW   = DW / 2;
  localparam int RMW  = RW + 4;
  localparam int SQN  = RW;
  localparam int STW  = STATUS_W + 2 * W;
  localparam int NSW  = W + 3;
  localparam int NMW  = W + 2 + F;
  localparam int DENW = W + 1;
  localparam int DTW  = STATUS_W + 2;
  localparam int MXW  = (NMW > ROOT_W + 1) ? NMW : ROOT_W + 1;
  localparam int CMW  = (DW > TOL_W) ? DW : TOL_W;

  logic en;

  logic [TOL_W-1:0] tol_r;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[APB_AW-1] == REG_TOL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_wr) begin
      tol_r <= pwdata[TOL_W-1:0];
    end
  end

  assign prdata = (paddr[APB_AW-1] == REG_TOL) ? APB_DW'(tol_r) : '0;

  logic                         out_valid_r;
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // Input stage.
  logic                s0_v_r;
  logic signed [W-1:0] s0_a_r;
  logic signed [W-1:0] s0_b_r;
  logic signed [W-1:0] s0_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_a_r <= in_coef_a;
      s0_b_r <= in_coef_b;
      s0_c_r <= in_coef_c;
    end
  end

  // Product stage.
  logic                  s1_v_r;
  logic signed [W-1:0]   s1_a_r;
  logic signed [W-1:0]   s1_b_r;
  logic signed [2*W-1:0] s1_bb_r;
  logic signed [2*W-1:0] s1_ac_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_a_r  <= s0_a_r;
      s1_b_r  <= s0_b_r;
      s1_bb_r <= s0_b_r * s0_b_r;
      s1_ac_r <= s0_a_r * s0_c_r;
    end
  end

  // Discriminant and classification stage.
  logic signed [DW-1:0]  disc;
  logic [DW-1:0]         disc_mag;
  logic [STATUS_W-1:0]   st_nxt;
  logic                  s2_v_r;
  logic [STW-1:0]        s2_tag_r;
  logic [DW-1:0]         s2_x_r;

  always_comb begin
    disc     = DW'(s1_bb_r) - (DW'(s1_ac_r) <<< 2);
    disc_mag = disc[DW-1] ? DW'(-disc) : DW'(disc);
    if (s1_a_r == '0) begin
      st_nxt = ST_AZERO;
    end else if (CMW'(disc_mag) < CMW'(tol_r)) begin
      st_nxt = ST_ONE;
    end else if (disc[DW-1]) begin
      st_nxt = ST_NONE;
    end else begin
      st_nxt = ST_TWO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_tag_r <= {st_nxt, s1_a_r, s1_b_r};
      s2_x_r   <= disc[DW-1] ? '0 : DW'(disc);
    end
  end

  // Square root chain.
  logic           sq_v   [0:SQN];
  logic [DW-1:0]  sq_x   [0:SQN];
  logic [RMW-1:0] sq_rem [0:SQN];
  logic [RW-1:0]  sq_root[0:SQN];
  logic [STW-1:0] sq_tag [0:SQN];

  assign sq_v[0]    = s2_v_r;
  assign sq_x[0]    = s2_x_r;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_tag[0]  = s2_tag_r;

  for (genvar i = 0; i < SQN; i++) begin : g_sqrt
    qrs_sqrt_cell #(
      .DW(DW),
      .TW(STW)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .v_i   (sq_v[i]),
      .x_i   (sq_x[i]),
      .rem_i (sq_rem[i]),
      .root_i(sq_root[i]),
      .tag_i (sq_tag[i]),
      .v_o   (sq_v[i+1]),
      .x_o   (sq_x[i+1]),
      .rem_o (sq_rem[i+1]),
      .root_o(sq_root[i+1]),
      .tag_o (sq_tag[i+1])
    );
  end

  // Numerator stage.
  logic [STATUS_W-1:0]   sq_st;
  logic signed [W-1:0]   sq_a;
  logic signed [W-1:0]   sq_b;
  logic signed [NSW-1:0] nb;
  logic signed [NSW-1:0] ns;
  logic signed [NSW-1:0] np;
  logic signed [NSW-1:0] nm;
  logic [NSW-1:0]        np_abs;
  logic [NSW-1:0]        nm_abs;
  logic [DENW-1:0]       a_abs;
  logic                  s3_v_r;
  logic [DENW-1:0]       s3_den_r;
  logic [NMW-1:0]        s3_np_r;
  logic [NMW-1:0]        s3_nm_r;
  logic [DTW-1:0]        s3_tag_r;

  always_comb begin
    sq_st = sq_tag[SQN][STW-1 -: STATUS_W];
    sq_a  = sq_tag[SQN][2*W-1 -: W];
    sq_b  = sq_tag[SQN][W-1:0];
    nb    = -NSW'(sq_b);
    ns    = (sq_st == ST_TWO) ? NSW'(sq_root[SQN]) : '0;
    np    = nb + ns;
    nm    = nb - ns;
    np_abs = np[NSW-1] ? NSW'(-np) : NSW'(np);
    nm_abs = nm[NSW-1] ? NSW'(-nm) : NSW'(nm);
    a_abs  = sq_a[W-1] ? DENW'(-DENW'(sq_a)) : DENW'(sq_a);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= sq_v[SQN];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_den_r <= a_abs << 1;
      s3_np_r  <= {np_abs[NSW-2:0], {F{1'b0}}};
      s3_nm_r  <= {nm_abs[NSW-2:0], {F{1'b0}}};
      s3_tag_r <= {sq_st, np[NSW-1] ^ sq_a[W-1], nm[NSW-1] ^ sq_a[W-1]};
    end
  end

  // Divider chain.
  logic            dv_v  [0:NMW];
  logic [DENW-1:0] dv_den[0:NMW];
  logic [NMW-1:0]  dv_np [0:NMW];
  logic [DENW-1:0] dv_rp [0:NMW];
  logic [NMW-1:0]  dv_qp [0:NMW];
  logic [NMW-1:0]  dv_nm [0:NMW];
  logic [DENW-1:0] dv_rm [0:NMW];
  logic [NMW-1:0]  dv_qm [0:NMW];
  logic [DTW-1:0]  dv_tag[0:NMW];

  assign dv_v[0]   = s3_v_r;
  assign dv_den[0] = s3_den_r;
  assign dv_np[0]  = s3_np_r;
  assign dv_rp[0]  = '0;
  assign dv_qp[0]  = '0;
  assign dv_nm[0]  = s3_nm_r;
  assign dv_rm[0]  = '0;
  assign dv_qm[0]  = '0;
  assign dv_tag[0] = s3_tag_r;

  for (genvar j = 0; j < NMW; j++) begin : g_div
    qrs_div_cell #(
      .NW  (NMW),
      .DENW(DENW),
      .TW  (DTW)
    ) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .en   (en),
      .v_i  (dv_v[j]),
      .den_i(dv_den[j]),
      .np_i (dv_np[j]),
      .rp_i (dv_rp[j]),
      .qp_i (dv_qp[j]),
      .nm_i (dv_nm[j]),
      .rm_i (dv_rm[j]),
      .qm_i (dv_qm[j]),
      .tag_i(dv_tag[j]),
      .v_o  (dv_v[j+1]),
      .den_o(dv_den[j+1]),
      .np_o (dv_np[j+1]),
      .rp_o (dv_rp[j+1]),
      .qp_o (dv_qp[j+1]),
      .nm_o (dv_nm[j+1]),
      .rm_o (dv_rm[j+1]),
      .qm_o (dv_qm[j+1]),
      .tag_o(dv_tag[j+1])
    );
  end

  // Sign, saturation and output register.
  logic [STATUS_W-1:0] dv_st;
  logic                neg_p;
  logic                neg_m;
  logic [MXW-1:0]      mag_p;
  logic [MXW-1:0]      mag_m;
  logic [MXW-1:0]      sv_p;
  logic [MXW-1:0]      sv_m;
  logic                sat_p;
  logic                sat_m;
  logic                has_root;
  logic [ROOT_W-1:0]   rp_nxt;
  logic [ROOT_W-1:0]   rm_nxt;

  logic [STATUS_W-1:0] status_r;
  logic [ROOT_W-1:0]   plus_r;
  logic [ROOT_W-1:0]   minus_r;
  logic                sat_r;

  always_comb begin
    dv_st    = dv_tag[NMW][DTW-1 -: STATUS_W];
    neg_p    = dv_tag[NMW][1];
    neg_m    = dv_tag[NMW][0];
    mag_p    = MXW'(dv_qp[NMW]);
    mag_m    = MXW'(dv_qm[NMW]);
    sv_p     = neg_p ? (~mag_p + 1'b1) : mag_p;
    sv_m     = neg_m ? (~mag_m + 1'b1) : mag_m;
    sat_p    = neg_p ? (mag_p > MXW'(ROOT_MIN_MAG)) : (mag_p > MXW'(ROOT_MAX_MAG));
    sat_m    = neg_m ? (mag_m > MXW'(ROOT_MIN_MAG)) : (mag_m > MXW'(ROOT_MAX_MAG));
    has_root = (dv_st == ST_ONE) || (dv_st == ST_TWO);
    if (!has_root) begin
      rp_nxt = '0;
    end else if (sat_p) begin
      rp_nxt = neg_p ? ROOT_MIN : ROOT_MAX;
    end else begin
      rp_nxt = sv_p[ROOT_W-1:0];
    end
    if (!has_root) begin
      rm_nxt = '0;
    end else if (sat_m) begin
      rm_nxt = neg_m ? ROOT_MIN : ROOT_MAX;
    end else begin
      rm_nxt = sv_m[ROOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_v[NMW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      status_r <= dv_st;
      plus_r   <= rp_nxt;
      minus_r  <= rm_nxt;
      sat_r    <= has_root && (sat_p || sat_m);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_root_status = status_r;
  assign out_root_plus   = plus_r;
  assign out_root_minus  = minus_r;
  assign out_saturated   = sat_r;

  a_azero_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r == ST_AZERO)) |-> (plus_r == '0 && minus_r == '0 && !sat_r))
    else $error("Degenerate transaction carries nonzero roots.");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r == ST_NONE)) |-> (plus_r == '0 && minus_r == '0 && !sat_r))
    else $error("Rootless transaction carries nonzero roots.");

  a_one_equal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r == ST_ONE)) |-> (plus_r == minus_r))
    else $error("Single root transaction has differing roots.");

  a_sat_extreme: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && sat_r) |-> (plus_r == ROOT_MAX || plus_r == ROOT_MIN ||
                                minus_r == ROOT_MAX || minus_r == ROOT_MIN))
    else $error("Saturation flag set without a clipped root.");

endmodule
`default_nettype wire

/* design/qrs_sqrt_cell.sv */
// One cell of the pipelined square root chain; resolves one root bit.
// Consumes the two top radicand bits and passes the rest to the next cell.
// Depends on nothing beyond its ports.
`default_nettype none
module qrs_sqrt_cell #(
  parameter int DW = 34,
  parameter int TW = 34
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              v_i,
  input  wire logic [DW-1:0]     x_i,
  input  wire logic [DW/2+3:0]   rem_i,
  input  wire logic [DW/2-1:0]   root_i,
  input  wire logic [TW-1:0]     tag_i,
  output logic                   v_o,
  output logic [DW-1:0]          x_o,
  output logic [DW/2+3:0]        rem_o,
  output logic [DW/2-1:0]        root_o,
  output logic [TW-1:0]          tag_o
);

  localparam int RW  = DW / 2;
  localparam int RMW = RW + 4;

  logic [RMW-1:0] shifted;
  logic [RMW-1:0] trial;
  logic           take;
  logic           v_r;
  logic [DW-1:0]  x_r;
  logic [RMW-1:0] rem_r;
  logic [RW-1:0]  root_r;
  logic [TW-1:0]  tag_r;

  always_comb begin
    shifted = {rem_i[RMW-3:0], x_i[DW-1:DW-2]};
    trial   = {2'b00, root_i, 2'b01};
    take    = (shifted >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= {x_i[DW-3:0], 2'b00};
      rem_r  <= take ? (shifted - trial) : shifted;
      root_r <= {root_i[RW-2:0], take};
      tag_r  <= tag_i;
    end
  end

  assign v_o    = v_r;
  assign x_o    = x_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign tag_o  = tag_r;

endmodule
`default_nettype wire

/* design/qrs_div_cell.sv */
// One cell of the pipelined divider chain; resolves one quotient bit for
// each of the two root lanes against a shared divisor. No dependencies.
`default_nettype none
module qrs_div_cell #(
  parameter int NW   = 34,
  parameter int DENW = 17,
  parameter int TW   = 4
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            v_i,
  input  wire logic [DENW-1:0] den_i,
  input  wire logic [NW-1:0]   np_i,
  input  wire logic [DENW-1:0] rp_i,
  input  wire logic [NW-1:0]   qp_i,
  input  wire logic [NW-1:0]   nm_i,
  input  wire logic [DENW-1:0] rm_i,
  input  wire logic [NW-1:0]   qm_i,
  input  wire logic [TW-1:0]   tag_i,
  output logic                 v_o,
  output logic [DENW-1:0]      den_o,
  output logic [NW-1:0]        np_o,
  output logic [DENW-1:0]      rp_o,
  output logic [NW-1:0]        qp_o,
  output logic [NW-1:0]        nm_o,
  output logic [DENW-1:0]      rm_o,
  output logic [NW-1:0]        qm_o,
  output logic [TW-1:0]        tag_o
);

  logic [DENW:0]   sp;
  logic [DENW:0]   sm;
  logic [DENW:0]   dx;
  logic            tp;
  logic            tm;
  logic [DENW:0]   dp;
  logic [DENW:0]   dm;
  logic            v_r;
  logic [DENW-1:0] den_r;
  logic [NW-1:0]   np_r;
  logic [DENW-1:0] rp_r;
  logic [NW-1:0]   qp_r;
  logic [NW-1:0]   nm_r;
  logic [DENW-1:0] rm_r;
  logic [NW-1:0]   qm_r;
  logic [TW-1:0]   tag_r;

  always_comb begin
    sp = {rp_i, np_i[NW-1]};
    sm = {rm_i, nm_i[NW-1]};
    dx = {1'b0, den_i};
    tp = (sp >= dx);
    tm = (sm >= dx);
    dp = tp ? (sp - dx) : sp;
    dm = tm ? (sm - dx) : sm;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r <= den_i;
      np_r  <= {np_i[NW-2:0], 1'b0};
      nm_r  <= {nm_i[NW-2:0], 1'b0};
      rp_r  <= dp[DENW-1:0];
      rm_r  <= dm[DENW-1:0];
      qp_r  <= {qp_i[NW-2:0], tp};
      qm_r  <= {qm_i[NW-2:0], tm};
      tag_r <= tag_i;
    end
  end

  assign v_o   = v_r;
  assign den_o = den_r;
  assign np_o  = np_r;
  assign rp_o  = rp_r;
  assign qp_o  = qp_r;
  assign nm_o  = nm_r;
  assign rm_o  = rm_r;
  assign qm_o  = qm_r;
  assign tag_o = tag_r;

endmodule
`default_nettype wire

/* bench/tb_quadratic_root_solver.sv */
// Testbench for quadratic_root_solver: a directed table, a zero tolerance pair, then random coefficient
// transactions under varied sender and receiver idling, checked against a local predictor.
// Depends on qrs_pkg and the quadratic_root_solver RTL.
`default_nettype none
module tb_quadratic_root_solver;
  import qrs_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [ROOT_W-1:0] plus;
    logic signed [ROOT_W-1:0] minus;
    logic                     sat;
  } root_result_t;

  typedef struct {
    logic signed [15:0] a, b, c;
    bit                 typed;
    root_result_t       res;
  } coef_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_coef_a = '0, in_coef_b = '0, in_coef_c = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [STATUS_W-1:0] out_root_status;
  logic signed [ROOT_W-1:0] out_root_plus, out_root_minus;
  logic out_saturated;

  root_result_t expected_roots[$];
  logic [TOL_W-1:0] tolerance;
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;
  int sent_count = 0;
  int checked_count = 0;

  quadratic_root_solver dut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_coef_a(in_coef_a), .in_coef_b(in_coef_b), .in_coef_c(in_coef_c),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_root_status(out_root_status), .out_root_plus(out_root_plus),
    .out_root_minus(out_root_minus), .out_saturated(out_saturated)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #(20 * 400000);
    $display("FAILURE");
    $finish;
  end

  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned r;
    longint unsigned bt;
    r = 0;
    bt = 64'd1 << 62;
    while (bt > x) bt >>= 2;
    while (bt != 0) begin
      if (x >= r + bt) begin
        x -= r + bt;
        r = (r >> 1) + bt;
      end else begin
        r >>= 1;
      end
      bt >>= 2;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] clipped_quotient(longint num, longint den,
                                                         inout logic sat);
    longint q;
    q = (num * 65536) / den;
    if (q > 64'sd2147483647) begin
      sat = 1'b1;
      return ROOT_MAX;
    end
    if (q < -64'sd2147483648) begin
      sat = 1'b1;
      return ROOT_MIN;
    end
    return q[31:0];
  endfunction

  function automatic root_result_t solve_roots(logic signed [15:0] ca, logic signed [15:0] cb,
                                               logic signed [15:0] cc);
    root_result_t r;
    longint a, b, c, d, s;
    longint unsigned mag;
    a = ca;
    b = cb;
    c = cc;
    r = '0;
    if (a == 0) begin
      r.status = ST_AZERO;
    end else begin
      d = b * b - 4 * a * c;
      mag = (d < 0) ? -d : d;
      if (mag < tolerance) begin
        r.status = ST_ONE;
        r.plus = clipped_quotient(-b, 2 * a, r.sat);
        r.minus = r.plus;
      end else if (d < 0) begin
        r.status = ST_NONE;
      end else begin
        s = floor_sqrt(d);
        r.status = ST_TWO;
        r.plus = clipped_quotient(-b + s, 2 * a, r.sat);
        r.minus = clipped_quotient(-b - s, 2 * a, r.sat);
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (hold_go && !hold_done) begin
      out_stall <= 1'b1;
      hold_done <= 1'b1;
      hold_cycles <= 199;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_roots.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        root_result_t e;
        e = expected_roots.pop_front();
        checked_count++;
        if (out_root_status !== e.status) begin
          $error("root_status expected %0d got %0d", e.status, out_root_status);
          errors++;
        end
        if (out_root_plus !== e.plus) begin
          $error("root_plus expected %0d got %0d", e.plus, out_root_plus);
          errors++;
        end
        if (out_root_minus !== e.minus) begin
          $error("root_minus expected %0d got %0d", e.minus, out_root_minus);
          errors++;
        end
        if (out_saturated !== e.sat) begin
          $error("saturated expected %0d got %0d", e.sat, out_saturated);
          errors++;
        end
      end
    end
  end

  task automatic write_tolerance(logic [TOL_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= APB_AW'(4 * int'(REG_TOL));
    pwdata <= APB_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tolerance = value;
  endtask

  task automatic send_coefs(logic signed [15:0] a, logic signed [15:0] b,
                            logic signed [15:0] c, bit typed, root_result_t res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_coef_a <= a;
    in_coef_b <= b;
    in_coef_c <= c;
    do @(posedge clk); while (in_stall);
    expected_roots.push_back(typed ? res : solve_roots(a, b, c));
    sent_count++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    wait (expected_roots.size() == 0);
    repeat (70) @(posedge clk);
  endtask

  task automatic send_random();
    logic signed [15:0] a, b, c;
    longint q;
    a = 16'($urandom);
    b = 16'($urandom);
    c = 16'($urandom);
    case ($urandom_range(5))
      0: begin
        a = 16'($urandom_range(1023) - 512);
        b = 16'($urandom_range(4095) - 2048);
        c = 16'($urandom_range(4095) - 2048);
      end
      1: begin
        if (a == 0) a = 16'sd256;
        q = (longint'(b) * longint'(b)) / (4 * longint'(a));
        q = q + $signed(32'($urandom_range(4))) - 2;
        c = (q > 32767) ? 16'sh7FFF : (q < -32768) ? 16'sh8000 : q[15:0];
      end
      2: a = 16'($urandom_range(1)) ? 16'sd0 : 16'sd1;
      3: begin
        a = 16'($urandom_range(1)) ? 16'sd1 : -16'sd1;
        b = 16'($urandom_range(1)) ? 16'sh7FFF : 16'sh8000;
      end
      default: ;
    endcase
    send_coefs(a, b, c, 1'b0, '0);
  endtask

  coef_row_t directed[] = '{
    '{16'sd0, 16'sd0, 16'sd0, 1'b1, '{ST_AZERO, 32'sd0, 32'sd0, 1'b0}},
    '{16'sd0, 16'sh7FFF, 16'sh8000, 1'b1, '{ST_AZERO, 32'sd0, 32'sd0, 1'b0}},
    '{16'sd256, 16'sd0, 16'sd256, 1'b1, '{ST_NONE, 32'sd0, 32'sd0, 1'b0}},
    '{16'sd256, 16'sd512, 16'sd256, 1'b1, '{ST_ONE, -32'sd65536, -32'sd65536, 1'b0}},
    '{16'sd256, 16'sd0, -16'sd256, 1'b1, '{ST_TWO, 32'sd65536, -32'sd65536, 1'b0}},
    '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0, '0},
    '{16'sh8000, 16'sh8000, 16'sh8000, 1'b0, '0},
    '{16'sh8000, 16'sh8000, 16'sh7FFF, 1'b0, '0},
    '{16'sh7FFF, 16'sh8000, 16'sh8000, 1'b0, '0},
    '{16'sd1, 16'sh8000, 16'sh8000, 1'b0, '0},
    '{-16'sd1, 16'sh7FFF, 16'sh7FFF, 1'b0, '0},
    '{16'sd1, 16'sh7FFF, 16'sd0, 1'b0, '0},
    '{16'sd1, 16'sd0, 16'sd0, 1'b0, '0},
    '{-16'sd1, -16'sd1, 16'sd0, 1'b0, '0},
    '{16'sd100, 16'sd21, 16'sd1, 1'b0, '0},
    '{-16'sd300, 16'sd5000, -16'sd7, 1'b0, '0},
    '{16'sd3, 16'shFFFF, 16'sh5555, 1'b0, '0},
    '{16'shAAAA, 16'sh5555, 16'shAAAA, 1'b0, '0}
  };

  initial begin
    tolerance = TOL_RESET;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i])
      send_coefs(directed[i].a, directed[i].b, directed[i].c, directed[i].typed,
                 directed[i].res);
    drain();
    // With a zero tolerance an exact zero discriminant yields two equal roots.
    write_tolerance('0);
    send_coefs(16'sd256, 16'sd512, 16'sd256, 1'b1,
               '{ST_TWO, -32'sd65536, -32'sd65536, 1'b0});
    send_coefs(16'sd1, 16'sd2, 16'sd1, 1'b0, '0);
    drain();
    write_tolerance(16'hFFFF);
    send_idle_pct = 22;
    recv_idle_pct = 81;
    for (int i = 0; i < 130; i++) send_random();
    drain();
    write_tolerance(16'($urandom_range(4096)));
    send_idle_pct = 81;
    recv_idle_pct = 22;
    for (int i = 0; i < 130; i++) begin
      if (i == 60) begin
        in_valid <= 1'b0;
        wait (expected_roots.size() == 0);
      end
      send_random();
    end
    drain();
    write_tolerance(TOL_RESET);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 130; i++) begin
      if (i == 10) hold_go = 1'b1;
      send_random();
    end
    in_valid <= 1'b0;
    wait (expected_roots.size() == 0);
    repeat (70) @(posedge clk);
    $display("Covered %0d coefficient transactions, %0d results checked, over five",
             sent_count, checked_count);
    $display("tolerance settings including zero and full scale, with varied idling.");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* filelist.f */
design/qrs_pkg.sv
design/qrs_sqrt_cell.sv
design/qrs_div_cell.sv
design/quadratic_root_solver.sv
bench/tb_quadratic_root_solver.sv
